// File: rtl/lcsm_pkg.sv
// Shared types and constants for the last-change source merge block.
package lcsm_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int DIMMER_PERIOD_DEF = 64;
  localparam int DIMMER_FRAME_BYTES_DEF = 17;

  localparam logic [15:0] FRAME_GAP_RESET = 16'd10;
  localparam logic [7:0] LEVEL_RESET = 8'h9f;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_LINK_A = 3'd1;
  localparam logic [2:0] CMD_LINK_B = 3'd2;
  localparam logic [2:0] CMD_PC_SET = 3'd3;
  localparam logic [2:0] CMD_PC_QUERY = 3'd4;

  localparam logic [1:0] KIND_DIMMER = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [7:0] REPLY_SET = 8'd1;
  localparam logic [7:0] REPLY_QUERY = 8'd2;

  localparam logic [1:0] SRC_PC = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] cold;
    logic [7:0] warm;
    logic [1:0] act;
  } desc_t;

endpackage

// File: rtl/lcsm_core.sv
// Input register, link framing, level merge and tick counting.
module lcsm_core import lcsm_pkg::*; #(
  parameter int DIMMER_PERIOD = DIMMER_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  cold,
  input  logic [7:0]  warm,
  input  logic [7:0]  bra,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        room,
  output desc_t       desc
);

  localparam int PW = $clog2(DIMMER_PERIOD);
  localparam logic [PW-1:0] PHASE_LAST = PW'(DIMMER_PERIOD - 1);

  logic        hv;
  logic [2:0]  hcmd;
  logic [7:0]  hdata;
  logic [7:0]  hcold;
  logic [7:0]  hwarm;
  logic [7:0]  hbra;

  logic [15:0] frame_gap;
  logic [15:0] tick_count;
  logic [PW-1:0] phase;
  logic [15:0] last_byte_tick [2];
  logic [3:0]  frame_fill [2];
  logic [7:0]  frame_store [16];
  logic [7:0]  cold_level [3];
  logic [7:0]  warm_level [3];
  logic [7:0]  bra_level [3];
  logic [1:0]  active_source;

  logic        is_tick;
  logic        is_link;
  logic        is_set;
  logic        is_query;
  logic        link;
  logic [15:0] tick_next;
  logic [PW-1:0] phase_next;
  logic        dim;
  logic        produce;
  logic        fire;
  logic [15:0] gap;
  logic [3:0]  fill_eff;
  logic        can_store;
  logic [3:0]  fill_new;
  logic        frame_done;
  logic        mrg_en;
  logic [1:0]  msrc;
  logic [7:0]  mc;
  logic [7:0]  mw;
  logic [7:0]  mb;
  logic        changed;
  logic [1:0]  act_src;

  assign is_tick = (hcmd == CMD_TICK);
  assign is_link = (hcmd == CMD_LINK_A) || (hcmd == CMD_LINK_B);
  assign is_set = (hcmd == CMD_PC_SET);
  assign is_query = (hcmd == CMD_PC_QUERY);
  assign link = (hcmd == CMD_LINK_B);

  assign tick_next = tick_count + 16'd1;
  assign phase_next = (tick_next == 16'd0 || phase == PHASE_LAST) ? '0 : phase + PW'(1);
  assign dim = (phase_next == PHASE_LAST);

  assign produce = is_set || is_query || (is_tick && dim);
  assign fire = hv && (!produce || room);
  assign in_ready = !hv || fire;

  assign gap = tick_count - last_byte_tick[link];
  assign fill_eff = (gap >= frame_gap) ? 4'd0 : frame_fill[link];
  assign can_store = (fill_eff < 4'(FRAME_BYTES));
  assign fill_new = fill_eff + 4'd1;
  assign frame_done = can_store && (fill_new == 4'(FRAME_BYTES)) &&
                      (frame_store[{link, 3'd0}] == 8'd0);

  always_comb begin
    mrg_en = 1'b0;
    msrc = SRC_PC;
    mc = hcold;
    mw = hwarm;
    mb = hbra;
    if (is_set) begin
      mrg_en = 1'b1;
    end else if (is_link && frame_done) begin
      mrg_en = 1'b1;
      msrc = {1'b0, link};
      mc = frame_store[{link, 3'd3}];
      mw = frame_store[{link, 3'd4}];
      mb = hdata;
    end
  end

  assign changed = (cold_level[msrc] != mc) || (warm_level[msrc] != mw) ||
                   (bra_level[msrc] != mb);
  assign act_src = (active_source == 2'd3) ? SRC_PC : active_source;

  always_comb begin
    desc.valid = fire && produce;
    desc.kind = is_set ? KIND_SET : (is_query ? KIND_QUERY : KIND_DIMMER);
    desc.cold = cold_level[act_src];
    desc.warm = warm_level[act_src];
    desc.act = active_source;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hcmd <= cmd;
      hdata <= data_byte;
      hcold <= cold;
      hwarm <= warm;
      hbra <= bra;
    end
    if (rst) begin
      hv <= 1'b0;
    end else if (in_valid && in_ready) begin
      hv <= 1'b1;
    end else if (fire) begin
      hv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap <= FRAME_GAP_RESET;
    end else if (cfg_we) begin
      frame_gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      phase <= '0;
      last_byte_tick[0] <= '0;
      last_byte_tick[1] <= '0;
      frame_fill[0] <= '0;
      frame_fill[1] <= '0;
      for (int i = 0; i < 16; i++) begin
        frame_store[i] <= 8'hff;
      end
      cold_level[0] <= LEVEL_RESET;
      cold_level[1] <= '0;
      cold_level[2] <= '0;
      warm_level[0] <= LEVEL_RESET;
      warm_level[1] <= '0;
      warm_level[2] <= '0;
      bra_level[0] <= '0;
      bra_level[1] <= '0;
      bra_level[2] <= '0;
      active_source <= '0;
    end else if (fire) begin
      if (is_tick) begin
        tick_count <= tick_next;
        phase <= phase_next;
      end
      if (is_link) begin
        last_byte_tick[link] <= tick_count;
        frame_fill[link] <= can_store ? fill_new : fill_eff;
        if (can_store) begin
          frame_store[{link, fill_eff[2:0]}] <= hdata;
        end
      end
      if (mrg_en && changed) begin
        cold_level[msrc] <= mc;
        warm_level[msrc] <= mw;
        bra_level[msrc] <= mb;
        active_source <= msrc;
      end
    end
  end

endmodule

// File: rtl/lcsm_emit.sv
// Result serializer: expands one reply or dimmer descriptor into output words.
module lcsm_emit import lcsm_pkg::*; #(
  parameter int DIMMER_FRAME_BYTES = DIMMER_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      desc,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       port,
  output logic [7:0] out_byte,
  output logic       last
);

  localparam int IW = $clog2(DIMMER_FRAME_BYTES);
  localparam logic [IW-1:0] DIM_LAST = IW'(DIMMER_FRAME_BYTES - 1);

  logic          busy;
  logic [1:0]    kind;
  logic [7:0]    lvl_cold;
  logic [7:0]    lvl_warm;
  logic [1:0]    act;
  logic [IW-1:0] idx;

  logic          load;
  logic [7:0]    val;
  logic          final_word;

  assign load = busy && (!out_valid || out_ready);
  assign room = !busy || (load && final_word);

  always_comb begin
    val = '0;
    final_word = 1'b0;
    case (kind)
      KIND_SET: begin
        val = (idx == '0) ? REPLY_SET : 8'd0;
        final_word = (idx == IW'(1));
      end
      KIND_QUERY: begin
        if (idx == '0) begin
          val = REPLY_QUERY;
        end else if (idx == IW'(2)) begin
          val = {6'd0, act};
        end
        final_word = (idx == IW'(2));
      end
      default: begin
        if (idx == IW'(1)) begin
          val = lvl_cold;
        end else if (idx == IW'(2)) begin
          val = lvl_warm;
        end
        final_word = (idx == DIM_LAST);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (desc.valid) begin
      kind <= desc.kind;
      lvl_cold <= desc.cold;
      lvl_warm <= desc.warm;
      act <= desc.act;
    end
    if (load) begin
      port <= (kind != KIND_DIMMER);
      out_byte <= val;
      last <= final_word;
    end
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (desc.valid) begin
        busy <= 1'b1;
        idx <= '0;
      end else begin
        if (load) begin
          idx <= idx + IW'(1);
        end
        if (load && final_word) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/last_change_source_merge.sv
// Top level of the last-change source merge block.
// Usage:
//   Input channel (in_valid/in_ready) takes one command word per cycle unless
//   stalled: tick, a switch link A or B byte, a pc set with levels or a pc query.
//   Output channel (out_valid/out_ready) gives one byte per word with its
//   port (0 dimmer, 1 pc reply) and last on the closing byte of a frame.
//   cfg_we/cfg_data write the idle gap, in ticks, that restarts a link frame.
// Order: a command lands in the input register and is applied from there; the
//   serializer registers its descriptor and then registers its first result byte.
// Throughput: one command per cycle when it yields no bytes. A pc set gives
//   2 bytes, a query 3 and a dimmer tick DIMMER_FRAME_BYTES; the serializer
//   emits one byte per cycle while out_ready allows, so a producing command
//   waits in the input register until the previous frame is on its last byte.
// Reset: levels return to their defaults, frames and tick count clear, the
//   gap returns to 10 ticks and both channels go empty.
// Stall: a held output byte stays put, the serializer and then the input
//   register fill, and in_ready drops; commands that yield nothing still
//   pass while the serializer is busy.
module last_change_source_merge import lcsm_pkg::*; #(
  parameter int DIMMER_PERIOD = DIMMER_PERIOD_DEF,
  parameter int DIMMER_FRAME_BYTES = DIMMER_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  cold,
  input  logic [7:0]  warm,
  input  logic [7:0]  bra,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        port,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  desc_t desc;
  logic  room;

  lcsm_core #(
    .DIMMER_PERIOD(DIMMER_PERIOD)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .data_byte(data_byte),
    .cold(cold),
    .warm(warm),
    .bra(bra),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .room(room),
    .desc(desc)
  );

  lcsm_emit #(
    .DIMMER_FRAME_BYTES(DIMMER_FRAME_BYTES)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .desc(desc),
    .room(room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .port(port),
    .out_byte(out_byte),
    .last(last)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("channels not empty after reset");

  a_reply_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && port && last |-> out_byte <= 8'd2)
    else $error("pc reply ends in a byte above the source range");

  a_desc_room: assert property (@(posedge clk) disable iff (rst)
    desc.valid |=> ##1 out_valid)
    else $error("descriptor taken without a word following");

endmodule
